@@ sv/wwrs_pkg.sv @@
`timescale 1ns / 1ps

package wwrs_pkg;

  localparam int MAX_SPLITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int TAG_W     = 16;
  localparam int WEIGHT_W  = 32;
  localparam int RAND_W    = 16;
  localparam int CFG_IDX_W = 2;
  // wide enough for the copy-weight divider's step count (WEIGHT_W + 1 steps)
  localparam int CNT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVAL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DECIDE,
    ST_NDIV,
    ST_NFIX,
    ST_WDIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic decide;
    logic ndiv_step;
    logic nfix;
    logic wdiv_step;
    logic copy_next;
  } wwrs_cmd_t;

  typedef struct packed {
    logic is_low;
    logic is_high;
    logic survive;
    logic cnt_zero;
    logic last;
  } wwrs_status_t;

endpackage

@@ sv/weight_window_roulette_split_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    particle_tag_i, weight_in_i, random_fraction_i
// out       out_valid_o / out_ready_i  tag_out_o, weight_out_o, last_copy_o
// cfg       cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// One particle at a time. A pass-through or surviving roulette particle is
// loaded, multiplied and classified before its result is offered. A split particle
// is classified and then goes through a radix-2 divider for the copy count, with
// QB = clog2(MAX_SPLITS) + 1 quotient bits, then a 33-step divider for the copy
// weight. Reset is asynchronous, active low, and loads the default window.
// A stalled result holds until out_ready_i; no new particle is taken until
// the last copy has been delivered.

module weight_window_roulette_split_top #(
  parameter int MAX_SPLITS = wwrs_pkg::MAX_SPLITS_DEF,
  parameter int FRAC_BITS  = wwrs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wwrs_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [wwrs_pkg::WEIGHT_W-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wwrs_pkg::TAG_W-1:0]     particle_tag_i,
  input  logic [wwrs_pkg::WEIGHT_W-1:0]  weight_in_i,
  input  logic [wwrs_pkg::RAND_W-1:0]    random_fraction_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wwrs_pkg::TAG_W-1:0]     tag_out_o,
  output logic [wwrs_pkg::WEIGHT_W-1:0]  weight_out_o,
  output logic                           last_copy_o
);

  wwrs_pkg::wwrs_cmd_t    cmd;
  wwrs_pkg::wwrs_status_t status;

  wwrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wwrs_dp #(
    .MAX_SPLITS (MAX_SPLITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .particle_tag_i    (particle_tag_i),
    .weight_in_i       (weight_in_i),
    .random_fraction_i (random_fraction_i),
    .tag_out_o         (tag_out_o),
    .weight_out_o      (weight_out_o),
    .last_copy_o       (last_copy_o),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule

@@ sv/wwrs_ctrl.sv @@
`timescale 1ns / 1ps

module wwrs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  wwrs_pkg::wwrs_status_t status_i,
  output wwrs_pkg::wwrs_cmd_t    cmd_o
);

  wwrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wwrs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      wwrs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wwrs_pkg::ST_MUL;
        end
      end
      wwrs_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = wwrs_pkg::ST_DECIDE;
      end
      wwrs_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (status_i.is_low) begin
          // roulette: a loser leaves no result
          state_d = status_i.survive ? wwrs_pkg::ST_EMIT : wwrs_pkg::ST_IDLE;
        end else if (status_i.is_high) begin
          state_d = wwrs_pkg::ST_NDIV;
        end else begin
          state_d = wwrs_pkg::ST_EMIT;
        end
      end
      wwrs_pkg::ST_NDIV: begin
        cmd_o.ndiv_step = 1'b1;
        if (status_i.cnt_zero) begin
          state_d = wwrs_pkg::ST_NFIX;
        end
      end
      wwrs_pkg::ST_NFIX: begin
        cmd_o.nfix = 1'b1;
        state_d    = wwrs_pkg::ST_WDIV;
      end
      wwrs_pkg::ST_WDIV: begin
        cmd_o.wdiv_step = 1'b1;
        if (status_i.cnt_zero) begin
          state_d = wwrs_pkg::ST_EMIT;
        end
      end
      wwrs_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = wwrs_pkg::ST_IDLE;
          end else begin
            cmd_o.copy_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = wwrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/wwrs_dp.sv @@
`timescale 1ns / 1ps

module wwrs_dp #(
  parameter int MAX_SPLITS = wwrs_pkg::MAX_SPLITS_DEF,
  parameter int FRAC_BITS  = wwrs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wwrs_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [wwrs_pkg::WEIGHT_W-1:0]     cfg_wdata_i,
  input  logic [wwrs_pkg::TAG_W-1:0]        particle_tag_i,
  input  logic [wwrs_pkg::WEIGHT_W-1:0]     weight_in_i,
  input  logic [wwrs_pkg::RAND_W-1:0]       random_fraction_i,
  output logic [wwrs_pkg::TAG_W-1:0]        tag_out_o,
  output logic [wwrs_pkg::WEIGHT_W-1:0]     weight_out_o,
  output logic                              last_copy_o,
  input  wwrs_pkg::wwrs_cmd_t               cmd_i,
  output wwrs_pkg::wwrs_status_t            status_o
);

  localparam int WW  = wwrs_pkg::WEIGHT_W;
  localparam int RW  = wwrs_pkg::RAND_W;
  localparam int CW  = wwrs_pkg::CNT_W;
  // split count quotient bits: enough to exceed MAX_SPLITS before clamping
  localparam int QB  = $clog2(MAX_SPLITS) + 1;
  localparam int NB  = $clog2(MAX_SPLITS + 1);
  localparam int NW  = WW + 1 + QB;
  localparam int WNB = WW + 1;

  localparam logic [WW-1:0] LOWER_RST =
    WW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [WW-1:0] UPPER_RST = WW'((64'd1 << FRAC_BITS) * 64'd10);
  localparam logic [WW-1:0] SURV_RST  = WW'(64'd1 << FRAC_BITS);
  localparam logic [QB-1:0] MAX_Q     = QB'(MAX_SPLITS);

  logic [WW-1:0]    lower_q, upper_q, surv_q;
  logic [wwrs_pkg::TAG_W-1:0] tag_q;
  logic [WW-1:0]    w_q;
  logic [RW-1:0]    rand_q;
  logic [RW+WW-1:0] prod_q;
  logic [NW-1:0]    rem_q, dsh_q;
  logic             ovf_q;
  logic [QB-1:0]    nq_q;
  logic [NB-1:0]    n_q, k_q, wrem_q;
  logic [WNB-1:0]   wnum_q;
  logic [CW-1:0]    cnt_q;

  logic [NW-1:0]    num_ext, den_ext;
  logic             rem_ge;
  logic [QB-1:0]    nclamp;
  logic [NB-1:0]    nclamp_nb;
  logic [NB:0]      wsh;
  logic             wge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RST;
      upper_q <= UPPER_RST;
      surv_q  <= SURV_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        wwrs_pkg::CFG_LOWER:    lower_q <= cfg_wdata_i;
        wwrs_pkg::CFG_UPPER:    upper_q <= cfg_wdata_i;
        wwrs_pkg::CFG_SURVIVAL: surv_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // rounded split count numerator 2w + s and divisor 2s
  assign num_ext = NW'({1'b0, w_q, 1'b0} + {2'b00, surv_q});
  assign den_ext = NW'({surv_q, 1'b0});
  assign rem_ge  = rem_q >= dsh_q;

  always_comb begin
    if (ovf_q || nq_q > MAX_Q) begin
      nclamp = MAX_Q;
    end else if (nq_q == '0) begin
      nclamp = QB'(1);
    end else begin
      nclamp = nq_q;
    end
  end
  assign nclamp_nb = NB'(nclamp);

  assign wsh = {wrem_q, wnum_q[WNB-1]};
  assign wge = wsh >= {1'b0, n_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q  <= particle_tag_i;
      w_q    <= weight_in_i;
      rand_q <= random_fraction_i;
      k_q    <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= rand_q * surv_q;
    end
    if (cmd_i.decide) begin
      if (status_o.is_low) begin
        wnum_q <= {1'b0, surv_q};
        n_q    <= NB'(1);
      end else if (status_o.is_high) begin
        rem_q <= num_ext;
        dsh_q <= den_ext << (QB - 1);
        ovf_q <= num_ext >= (den_ext << QB);
        nq_q  <= '0;
        cnt_q <= CW'(QB - 1);
      end else begin
        wnum_q <= {1'b0, w_q};
        n_q    <= NB'(1);
      end
    end
    if (cmd_i.ndiv_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      nq_q  <= {nq_q[QB-2:0], rem_ge};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - CW'(1);
    end
    if (cmd_i.nfix) begin
      n_q    <= nclamp_nb;
      wnum_q <= {1'b0, w_q} + WNB'(nclamp_nb >> 1);
      wrem_q <= '0;
      cnt_q  <= CW'(WNB - 1);
    end
    if (cmd_i.wdiv_step) begin
      // shift the next numerator bit in; quotient bits fill from the bottom
      wrem_q <= wge ? NB'(wsh - {1'b0, n_q}) : NB'(wsh);
      wnum_q <= {wnum_q[WNB-2:0], wge};
      cnt_q  <= cnt_q - CW'(1);
    end
    if (cmd_i.copy_next) begin
      k_q <= k_q + NB'(1);
    end
  end

  assign status_o.is_low   = w_q < lower_q;
  assign status_o.is_high  = w_q > upper_q;
  assign status_o.survive  = prod_q < {w_q, {RW{1'b0}}};
  assign status_o.cnt_zero = cnt_q == '0;
  assign status_o.last     = k_q == NB'(n_q - NB'(1));

  assign tag_out_o    = tag_q;
  assign weight_out_o = wnum_q[WW-1:0];
  assign last_copy_o  = status_o.last;

endmodule

@@ sv/wwrs_checker.sv @@
`timescale 1ns / 1ps

module wwrs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [wwrs_pkg::TAG_W-1:0]     tag_out_o,
  input logic [wwrs_pkg::WEIGHT_W-1:0]  weight_out_o,
  input logic                           last_copy_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tag_out_o)
      && $stable(weight_out_o) && $stable(last_copy_o))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result in the cycle after acceptance");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_copy_o |=> in_ready_o)
    else $error("input not ready after last copy");

  a_copies_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_copy_o |=> out_valid_o
      && $stable(tag_out_o) && $stable(weight_out_o))
    else $error("split copies broken up or altered");

endmodule

bind weight_window_roulette_split_top wwrs_checker u_wwrs_checker (.*);
